@@ rtl/core/nec_tx_pkg.sv @@
// Shared constants and types for the NEC infrared frame transmitter.
`timescale 1ns / 1ps

package nec_tx_pkg;

  // Default number of data bits in one frame.
  localparam int FRAME_BITS_DEF = 32;

  // Word widths on the stream channels.
  localparam int FUNC_W     = 2;
  localparam int ADDR_W     = 16;
  localparam int CMD_W      = 8;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 8;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 14;

  // Register widths.
  localparam int HALF_W   = 8;
  localparam int PERIOD_W = 10;
  localparam int TICK_W   = 14;
  localparam int PHASE_W  = 3;

  // Input word kinds.
  localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_FRAME  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_REPEAT = 2'd2;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_CARRIER_HALF = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEAD_BURST   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BIT_BURST    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LEAD_SPACE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_SPACE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_SPACE    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_SPACE = 3'd6;

  // Register reset values.
  localparam logic [HALF_W-1:0]   CARRIER_HALF_RST = 8'd13;
  localparam logic [PERIOD_W-1:0] LEAD_BURST_RST   = 10'd346;
  localparam logic [HALF_W-1:0]   BIT_BURST_RST    = 8'd21;
  localparam logic [TICK_W-1:0]   LEAD_SPACE_RST   = 14'd4500;
  localparam logic [TICK_W-1:0]   ZERO_SPACE_RST   = 14'd560;
  localparam logic [TICK_W-1:0]   ONE_SPACE_RST    = 14'd1680;
  localparam logic [TICK_W-1:0]   REPEAT_SPACE_RST = 14'd2250;

  // Transmit phases.
  localparam logic [PHASE_W-1:0] PH_IDLE       = 3'd0;
  localparam logic [PHASE_W-1:0] PH_LEAD_BURST = 3'd1;
  localparam logic [PHASE_W-1:0] PH_LEAD_SPACE = 3'd2;
  localparam logic [PHASE_W-1:0] PH_BIT_BURST  = 3'd3;
  localparam logic [PHASE_W-1:0] PH_BIT_SPACE  = 3'd4;
  localparam logic [PHASE_W-1:0] PH_STOP_BURST = 3'd5;

  // One result word.
  typedef struct packed {
    logic frame_done;
    logic busy_res;
    logic ir_out;
  } result_t;

endpackage

@@ rtl/core/nec_ir_frame_transmitter_core.sv @@
// NEC infrared frame transmitter: tick-driven waveform generator with a registered result.
`timescale 1ns / 1ps

// Usage
//   Input stream (s_axis_*): one word per microsecond tick or command. tuser is the
//   word kind: tick, start frame (address and command in tdata), or start repeat code.
//   A start word takes no waveform time; it arms the frame and reports busy. Starts
//   while a frame or repeat code is running are dropped.
//   Output stream (m_axis_*): exactly one result word per input word, in order:
//   the pin level for that tick, busy, and a done flag on the final tick.
//   Configuration (cfg_*): seven timing registers, always ready; write them only
//   while no transmission runs. Changes take effect on the next word.
// Throughput and result path
//   One word is accepted every cycle while the skid stage is empty. Its result is
//   registered after acceptance: the whole state update is one pass of counter
//   increments and limit compares between the state registers and the result register.
// Reset
//   rst (synchronous) returns the transmitter to idle, loads the default timing
//   registers and empties the result register and skid stage.
// Stall
//   When m_axis_tready is low, the held result stays put and one more word is
//   caught in a skid stage; s_axis_tready drops only while that stage is full.

module nec_ir_frame_transmitter_core
  import nec_tx_pkg::*;
#(
  parameter int FRAME_BITS = FRAME_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // input word
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [15:0] address, [23:16] command
  input  logic [FUNC_W-1:0]     s_axis_tuser,   // [1:0] func
  // result word
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [0] ir_out, [1] busy_res,
                                                // [2] frame_done, [7:3] zero
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int BI_W = (FRAME_BITS > 1) ? $clog2(FRAME_BITS) : 1;
  localparam logic [BI_W-1:0] LAST_BIT = BI_W'(FRAME_BITS - 1);

  // Timing registers
  logic [HALF_W-1:0]   carrier_half;
  logic [PERIOD_W-1:0] lead_burst;
  logic [HALF_W-1:0]   bit_burst;
  logic [TICK_W-1:0]   lead_space;
  logic [TICK_W-1:0]   zero_space;
  logic [TICK_W-1:0]   one_space;
  logic [TICK_W-1:0]   repeat_space;

  // Waveform state
  logic [PHASE_W-1:0]    phase, phase_next;
  logic                  repeat_mode, repeat_mode_next;
  logic [FRAME_BITS-1:0] frame_bits, frame_bits_next;
  logic [BI_W-1:0]       bit_index, bit_index_next;
  logic [TICK_W-1:0]     tick_count, tick_count_next;
  logic [PERIOD_W-1:0]   period_count, period_count_next;
  logic [HALF_W-1:0]     half_count, half_count_next;
  logic                  carrier_level, carrier_level_next;

  // Result register and skid stage
  logic    out_valid;
  result_t out_word;
  logic    skid_valid;
  result_t skid_word;

  logic    accept;
  result_t res;

  // Burst and space helpers
  logic [HALF_W-1:0]   half_inc;
  logic [PERIOD_W-1:0] period_inc;
  logic [PERIOD_W-1:0] burst_limit;
  logic [TICK_W-1:0]   tick_inc;
  logic [TICK_W-1:0]   space_limit;
  logic                half_wrap;
  logic                burst_end;
  logic                space_end;
  logic                in_burst;
  logic [31:0]         frame_word;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = !skid_valid;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Full 32-bit frame: address low, address high, command, inverted command.
  assign frame_word = {~s_axis_tdata[23:16], s_axis_tdata[23:16], s_axis_tdata[15:0]};

  assign in_burst = (phase == PH_LEAD_BURST) || (phase == PH_BIT_BURST) ||
                    (phase == PH_STOP_BURST);

  assign half_inc    = half_count + 1'b1;
  assign period_inc  = period_count + 1'b1;
  assign tick_inc    = tick_count + 1'b1;
  assign half_wrap   = (half_inc >= carrier_half);
  assign burst_limit = (phase == PH_LEAD_BURST) ? lead_burst
                                                : {{(PERIOD_W-HALF_W){1'b0}}, bit_burst};
  // A burst ends on the low-to-high edge that closes its last carrier period.
  assign burst_end   = half_wrap && !carrier_level && (period_inc >= burst_limit);

  always_comb begin
    space_limit = zero_space;
    if (phase == PH_LEAD_SPACE) begin
      space_limit = repeat_mode ? repeat_space : lead_space;
    end else if (frame_bits[bit_index]) begin
      space_limit = one_space;
    end
  end
  assign space_end = (tick_inc >= space_limit);

  // Next state and result for the word on the input
  always_comb begin
    phase_next         = phase;
    repeat_mode_next   = repeat_mode;
    frame_bits_next    = frame_bits;
    bit_index_next     = bit_index;
    tick_count_next    = tick_count;
    period_count_next  = period_count;
    half_count_next    = half_count;
    carrier_level_next = carrier_level;
    res                = '0;

    if (s_axis_tuser == FUNC_TICK) begin
      if (phase != PH_IDLE) begin
        res.busy_res = 1'b1;
        res.ir_out   = in_burst ? carrier_level : 1'b0;

        // Advance the carrier on every burst tick.
        if (in_burst) begin
          if (!half_wrap) begin
            half_count_next = half_inc;
          end else begin
            half_count_next    = '0;
            carrier_level_next = !carrier_level;
            if (!carrier_level) begin
              period_count_next = period_inc;
            end
          end
        end

        case (phase)
          PH_LEAD_BURST, PH_BIT_BURST: begin
            if (burst_end) begin
              phase_next         = (phase == PH_LEAD_BURST) ? PH_LEAD_SPACE : PH_BIT_SPACE;
              tick_count_next    = '0;
              carrier_level_next = 1'b0;
            end
          end
          PH_LEAD_SPACE, PH_BIT_SPACE: begin
            tick_count_next = tick_inc;
            if (space_end) begin
              half_count_next    = '0;
              period_count_next  = '0;
              carrier_level_next = 1'b1;
              if (phase == PH_LEAD_SPACE) begin
                bit_index_next = '0;
                phase_next     = repeat_mode ? PH_STOP_BURST : PH_BIT_BURST;
              end else if (bit_index == LAST_BIT) begin
                phase_next = PH_STOP_BURST;
              end else begin
                bit_index_next = bit_index + 1'b1;
                phase_next     = PH_BIT_BURST;
              end
            end
          end
          PH_STOP_BURST: begin
            if (burst_end) begin
              phase_next         = PH_IDLE;
              carrier_level_next = 1'b0;
              half_count_next    = '0;
              period_count_next  = '0;
              res.frame_done     = 1'b1;
            end
          end
          default: begin
            phase_next = PH_IDLE;
          end
        endcase
      end
    end else begin
      // Arm a frame or repeat code only from idle.
      if ((phase == PH_IDLE) &&
          ((s_axis_tuser == FUNC_FRAME) || (s_axis_tuser == FUNC_REPEAT))) begin
        if (s_axis_tuser == FUNC_FRAME) begin
          frame_bits_next  = frame_word[FRAME_BITS-1:0];
          repeat_mode_next = 1'b0;
        end else begin
          repeat_mode_next = 1'b1;
        end
        bit_index_next     = '0;
        tick_count_next    = '0;
        phase_next         = PH_LEAD_BURST;
        half_count_next    = '0;
        period_count_next  = '0;
        carrier_level_next = 1'b1;
      end
      res.busy_res = (phase_next != PH_IDLE);
      res.ir_out   = (phase_next != PH_IDLE) &&
                     ((phase_next == PH_LEAD_BURST) || (phase_next == PH_BIT_BURST) ||
                      (phase_next == PH_STOP_BURST)) && carrier_level_next;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      carrier_half <= CARRIER_HALF_RST;
      lead_burst   <= LEAD_BURST_RST;
      bit_burst    <= BIT_BURST_RST;
      lead_space   <= LEAD_SPACE_RST;
      zero_space   <= ZERO_SPACE_RST;
      one_space    <= ONE_SPACE_RST;
      repeat_space <= REPEAT_SPACE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CARRIER_HALF: carrier_half <= cfg_data[HALF_W-1:0];
        REG_LEAD_BURST:   lead_burst   <= cfg_data[PERIOD_W-1:0];
        REG_BIT_BURST:    bit_burst    <= cfg_data[HALF_W-1:0];
        REG_LEAD_SPACE:   lead_space   <= cfg_data;
        REG_ZERO_SPACE:   zero_space   <= cfg_data;
        REG_ONE_SPACE:    one_space    <= cfg_data;
        REG_REPEAT_SPACE: repeat_space <= cfg_data;
        default: begin
          // drop writes to unmapped indexes
        end
      endcase
    end
  end

  // Waveform state advances on every accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      repeat_mode   <= 1'b0;
      bit_index     <= '0;
      tick_count    <= '0;
      period_count  <= '0;
      half_count    <= '0;
      carrier_level <= 1'b0;
    end else if (accept) begin
      phase         <= phase_next;
      repeat_mode   <= repeat_mode_next;
      bit_index     <= bit_index_next;
      tick_count    <= tick_count_next;
      period_count  <= period_count_next;
      half_count    <= half_count_next;
      carrier_level <= carrier_level_next;
    end
  end

  // Frame payload is loaded by every frame start before it is read.
  always_ff @(posedge clk) begin
    if (accept) begin
      frame_bits <= frame_bits_next;
    end
  end

  // Result register with one skid stage behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || m_axis_tready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || m_axis_tready) begin
      out_word <= skid_valid ? skid_word : res;
    end else if (accept) begin
      skid_word <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OUT_DATA_W-3){1'b0}}, out_word};

endmodule

@@ rtl/core/nec_tx_checker.sv @@
// Port-level checks for the NEC infrared frame transmitter, bound to the top level.
`timescale 1ns / 1ps

module nec_tx_checker
  import nec_tx_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata
);

  // Hold a stalled result word.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result word changed or vanished");

  // The end of a transmission is part of that transmission.
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[2] |-> m_axis_tdata[1])
    else $error("frame_done without busy_res");

  // The pin emits only while a transmission runs.
  a_ir_busy: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[1])
    else $error("ir_out high while not busy");

  // Input backpressure only comes from a full result register.
  a_ready_out: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with empty result register");

  // Reset empties the output.
  a_reset_empty: assert property (@(posedge clk)
    !rst && $past(rst) |-> !m_axis_tvalid)
    else $error("result word valid right after reset");

endmodule

bind nec_ir_frame_transmitter_core nec_tx_checker u_nec_tx_checker (.*);

@@ tb/sv/testbench.sv @@
// Self-checking bench for the NEC infrared frame transmitter core.
`timescale 1ns / 1ps

module testbench;
  import nec_tx_pkg::*;

  // One word per tick or command in; one pin word back per word in.
  localparam int TX_BITS      = FRAME_BITS_DEF;
  localparam int QUIET_LIMIT  = 3000;  // cycles with no handshake before giving up
  localparam int DRAIN_CYCLES = 4;     // result register plus skid stage, with margin
  localparam int HOLD_CYCLES  = 120;   // long back-pressure stretch on the result side
  localparam int ZERO_TIMING_ROW = 3;  // directed row that runs under all-zero timing

  // Word kind with no meaning; the core must ignore it.
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;  // [15:0] address, [23:16] command
  logic [FUNC_W-1:0]     s_axis_tuser  = FUNC_TICK;  // [1:0] func
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;   // [0] ir_out, [1] busy_res, [2] frame_done
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_CARRIER_HALF;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // Idling odds in percent, and the request for one long result-side hold.
  int unsigned src_gap_pct    = 6;
  int unsigned sink_stall_pct = 59;
  bit          hold_req       = 1'b0;

  // Expected pin words, oldest first. A directed row may pin down its own value.
  result_t pending_pins[$];
  bit      fixed_valid = 1'b0;
  result_t fixed_word  = '0;
  int      mismatches  = 0;

  // Timing registers as the predictor sees them.
  logic [HALF_W-1:0]   half_ticks   = CARRIER_HALF_RST;
  logic [PERIOD_W-1:0] lead_periods = LEAD_BURST_RST;
  logic [HALF_W-1:0]   bit_periods  = BIT_BURST_RST;
  logic [TICK_W-1:0]   lead_space   = LEAD_SPACE_RST;
  logic [TICK_W-1:0]   zero_space   = ZERO_SPACE_RST;
  logic [TICK_W-1:0]   one_space    = ONE_SPACE_RST;
  logic [TICK_W-1:0]   rep_space    = REPEAT_SPACE_RST;

  // Transmitter state as the predictor sees it.
  logic [PHASE_W-1:0]  tx_phase    = PH_IDLE;
  logic                rep_mode    = 1'b0;
  logic [31:0]         frame_word  = '0;
  logic [4:0]          bit_pos     = '0;
  logic [TICK_W-1:0]   space_cnt   = '0;
  logic [PERIOD_W-1:0] period_cnt  = '0;
  logic [HALF_W-1:0]   half_cnt    = '0;
  logic                carrier_lvl = 1'b0;

  typedef struct {
    logic [FUNC_W-1:0] func;
    logic [ADDR_W-1:0] addr;
    logic [CMD_W-1:0]  cmd;
    bit                fixed;
    result_t           want;   // {frame_done, busy_res, ir_out}
  } probe_t;

  probe_t probes[$];

  nec_ir_frame_transmitter_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Waveform predictor
  // ---------------------------------------------------------------------------

  function automatic void start_burst(input logic [PHASE_W-1:0] ph);
    tx_phase    = ph;
    half_cnt    = '0;
    period_cnt  = '0;
    carrier_lvl = 1'b1;
  endfunction

  function automatic void start_space(input logic [PHASE_W-1:0] ph);
    tx_phase    = ph;
    space_cnt   = '0;
    carrier_lvl = 1'b0;
  endfunction

  function automatic bit in_burst();
    return tx_phase == PH_LEAD_BURST || tx_phase == PH_BIT_BURST ||
           tx_phase == PH_STOP_BURST;
  endfunction

  // One carrier tick; true once the last period of the burst has closed.
  // A zero limit acts as a limit of one, since the compare follows the increment.
  function automatic bit burst_advance(input int unsigned periods);
    half_cnt = half_cnt + 8'd1;
    if (half_cnt < half_ticks) return 1'b0;
    half_cnt = '0;
    if (carrier_lvl) begin
      carrier_lvl = 1'b0;
      return 1'b0;
    end
    carrier_lvl = 1'b1;
    period_cnt  = period_cnt + 10'd1;
    return int'(period_cnt) >= periods;
  endfunction

  function automatic bit space_advance(input logic [TICK_W-1:0] len);
    space_cnt = space_cnt + 14'd1;
    return space_cnt >= len;
  endfunction

  // Pin word caused by one input word; advances the predicted transmitter.
  function automatic result_t transmit_step(input logic [FUNC_W-1:0] func,
                                            input logic [ADDR_W-1:0] addr,
                                            input logic [CMD_W-1:0]  cmd);
    result_t r;
    r = '0;
    if (func == FUNC_TICK) begin
      if (tx_phase != PH_IDLE) begin
        // The pin shows the level held during this tick, before the update.
        r.busy_res = 1'b1;
        r.ir_out   = in_burst() ? carrier_lvl : 1'b0;
        case (tx_phase)
          PH_LEAD_BURST: begin
            if (burst_advance(lead_periods)) start_space(PH_LEAD_SPACE);
          end
          PH_LEAD_SPACE: begin
            if (space_advance(rep_mode ? rep_space : lead_space)) begin
              bit_pos = '0;
              start_burst(rep_mode ? PH_STOP_BURST : PH_BIT_BURST);
            end
          end
          PH_BIT_BURST: begin
            if (burst_advance(bit_periods)) start_space(PH_BIT_SPACE);
          end
          PH_BIT_SPACE: begin
            if (space_advance(frame_word[bit_pos] ? one_space : zero_space)) begin
              if (int'(bit_pos) >= TX_BITS - 1) begin
                start_burst(PH_STOP_BURST);
              end else begin
                bit_pos = bit_pos + 5'd1;
                start_burst(PH_BIT_BURST);
              end
            end
          end
          PH_STOP_BURST: begin
            if (burst_advance(bit_periods)) begin
              tx_phase     = PH_IDLE;
              carrier_lvl  = 1'b0;
              half_cnt     = '0;
              period_cnt   = '0;
              r.frame_done = 1'b1;
            end
          end
          default: tx_phase = PH_IDLE;
        endcase
      end
    end else begin
      // Starts take no time and are dropped while a transmission runs.
      if (tx_phase == PH_IDLE && (func == FUNC_FRAME || func == FUNC_REPEAT)) begin
        if (func == FUNC_FRAME) begin
          frame_word = {~cmd, cmd, addr};
          rep_mode   = 1'b0;
        end else begin
          rep_mode = 1'b1;
        end
        bit_pos   = '0;
        space_cnt = '0;
        start_burst(PH_LEAD_BURST);
      end
      r.busy_res = tx_phase != PH_IDLE;
      r.ir_out   = (tx_phase != PH_IDLE && in_burst()) ? carrier_lvl : 1'b0;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: check result words, predict accepted words, track register writes
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : monitor
    result_t want;
    result_t got;
    result_t calc;
    if (!rst) begin
      // Check first: a result never leaves in the cycle its word is accepted.
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[2:0];
        if (pending_pins.size() == 0) begin
          $error("result word %h with nothing pending", m_axis_tdata);
          mismatches++;
        end else begin
          want = pending_pins.pop_front();
          if (got.ir_out !== want.ir_out) begin
            $error("ir_out: expected %0b, got %0b", want.ir_out, got.ir_out);
            mismatches++;
          end
          if (got.busy_res !== want.busy_res) begin
            $error("busy_res: expected %0b, got %0b", want.busy_res, got.busy_res);
            mismatches++;
          end
          if (got.frame_done !== want.frame_done) begin
            $error("frame_done: expected %0b, got %0b", want.frame_done, got.frame_done);
            mismatches++;
          end
          if (m_axis_tdata[OUT_DATA_W-1:3] !== '0) begin
            $error("pad bits: expected 0, got %b", m_axis_tdata[OUT_DATA_W-1:3]);
            mismatches++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        calc = transmit_step(s_axis_tuser, s_axis_tdata[ADDR_W-1:0],
                             s_axis_tdata[ADDR_W+CMD_W-1:ADDR_W]);
        pending_pins.push_back(fixed_valid ? fixed_word : calc);
      end
      if (cfg_valid && cfg_ready) begin
        // Narrow registers keep only their low bits.
        case (cfg_index)
          REG_CARRIER_HALF: half_ticks   = cfg_data[HALF_W-1:0];
          REG_LEAD_BURST:   lead_periods = cfg_data[PERIOD_W-1:0];
          REG_BIT_BURST:    bit_periods  = cfg_data[HALF_W-1:0];
          REG_LEAD_SPACE:   lead_space   = cfg_data;
          REG_ZERO_SPACE:   zero_space   = cfg_data;
          REG_ONE_SPACE:    one_space    = cfg_data;
          REG_REPEAT_SPACE: rep_space    = cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Give up when no channel moves a word for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // Result side: random stalls, plus one long hold on request so that the
  // skid stage fills and the input side has to stall.
  initial begin : sink
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers; every task starts and ends at a falling edge
  // ---------------------------------------------------------------------------

  // Offer one word and hold it until accepted. Valid stays high on return so
  // that back-to-back words need no second assignment in the same step.
  task automatic put_word(input logic [FUNC_W-1:0] f, input logic [ADDR_W-1:0] a,
                          input logic [CMD_W-1:0] c, input bit fixed = 1'b0,
                          input result_t want = '0);
    while ($urandom_range(0, 99) < src_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= f;
    s_axis_tdata  <= {c, a};
    fixed_valid   <= fixed;
    fixed_word    <= want;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic load_timing(input logic [CFG_DATA_W-1:0] half, lead, bitb,
                             input logic [CFG_DATA_W-1:0] lsp, zsp, osp, rsp);
    write_reg(REG_CARRIER_HALF, half);
    write_reg(REG_LEAD_BURST, lead);
    write_reg(REG_BIT_BURST, bitb);
    write_reg(REG_LEAD_SPACE, lsp);
    write_reg(REG_ZERO_SPACE, zsp);
    write_reg(REG_ONE_SPACE, osp);
    write_reg(REG_REPEAT_SPACE, rsp);
    cfg_valid <= 1'b0;
  endtask

  // Short timing so frames finish in a few hundred ticks; junk above the
  // register width on the narrow registers must be dropped.
  task automatic load_random_timing();
    load_timing(CFG_DATA_W'(($urandom_range(0, 63) << 8) | $urandom_range(0, 2)),
                CFG_DATA_W'(($urandom_range(0, 15) << 10) | $urandom_range(0, 3)),
                CFG_DATA_W'(($urandom_range(0, 63) << 8) | $urandom_range(0, 2)),
                CFG_DATA_W'($urandom_range(0, 4)),
                CFG_DATA_W'($urandom_range(0, 3)),
                CFG_DATA_W'($urandom_range(0, 4)),
                CFG_DATA_W'($urandom_range(0, 4)));
  endtask

  // Tick the transmitter back to idle, then wait for every pin word to return.
  task automatic settle();
    while (tx_phase != PH_IDLE)
      put_word(FUNC_TICK, ADDR_W'($urandom), CMD_W'($urandom));
    s_axis_tvalid <= 1'b0;
    while (pending_pins.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Mostly well-formed frames and repeat codes with random content; the rest
  // is dropped starts, unused kinds and idle ticks.
  task automatic traffic(input int n);
    int k;
    int unsigned r;
    for (k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (tx_phase == PH_IDLE) begin
        if (r < 45)
          put_word(FUNC_FRAME, ADDR_W'($urandom), CMD_W'($urandom));
        else if (r < 70)
          put_word(FUNC_REPEAT, ADDR_W'($urandom), CMD_W'($urandom));
        else if (r < 80)
          put_word(FUNC_UNUSED, ADDR_W'($urandom), CMD_W'($urandom));
        else
          put_word(FUNC_TICK, ADDR_W'($urandom), CMD_W'($urandom));
      end else begin
        if (r < 92)
          put_word(FUNC_TICK, ADDR_W'($urandom), CMD_W'($urandom));
        else if (r < 95)
          put_word(FUNC_FRAME, ADDR_W'($urandom), CMD_W'($urandom));
        else if (r < 98)
          put_word(FUNC_REPEAT, ADDR_W'($urandom), CMD_W'($urandom));
        else
          put_word(FUNC_UNUSED, ADDR_W'($urandom), CMD_W'($urandom));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Run
  // ---------------------------------------------------------------------------

  initial begin : run
    int i;
    // Directed rows; typed values are {frame_done, busy_res, ir_out}.
    // Idle under reset timing: ticks and the unused kind leave the pin low.
    probes.push_back('{FUNC_TICK,   16'h0000, 8'h00, 1'b1, 3'b000});
    probes.push_back('{FUNC_UNUSED, 16'hffff, 8'hff, 1'b1, 3'b000});
    probes.push_back('{FUNC_TICK,   16'hffff, 8'hff, 1'b1, 3'b000});
    // All-zero timing from here: every count behaves as one.
    probes.push_back('{FUNC_REPEAT, 16'h0000, 8'h00, 1'b1, 3'b011});
    // Starts and the unused kind during a transmission change nothing.
    probes.push_back('{FUNC_FRAME,  16'hffff, 8'h00, 1'b1, 3'b011});
    probes.push_back('{FUNC_REPEAT, 16'h0000, 8'hff, 1'b1, 3'b011});
    probes.push_back('{FUNC_UNUSED, 16'hffff, 8'hff, 1'b1, 3'b011});
    repeat (5) probes.push_back('{FUNC_TICK, 16'h0000, 8'h00, 1'b0, 3'b000});
    probes.push_back('{FUNC_TICK,   16'h0000, 8'h00, 1'b1, 3'b000});
    // Frame with extreme address and command, and a dropped start inside it.
    probes.push_back('{FUNC_FRAME,  16'hffff, 8'h00, 1'b1, 3'b011});
    probes.push_back('{FUNC_FRAME,  16'h0000, 8'hff, 1'b0, 3'b000});
    repeat (6) probes.push_back('{FUNC_TICK, 16'hffff, 8'hff, 1'b0, 3'b000});

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Sender idles rarely, receiver often.
    src_gap_pct    = 6;
    sink_stall_pct = 59;
    for (i = 0; i < probes.size(); i++) begin
      if (i == ZERO_TIMING_ROW) begin
        settle();
        load_timing('0, '0, '0, '0, '0, '0, '0);
      end
      put_word(probes[i].func, probes[i].addr, probes[i].cmd, probes[i].fixed,
               probes[i].want);
    end

    settle();
    load_timing(14'd1, 14'd2, 14'd1, 14'd3, 14'd1, 14'd3, 14'd2);
    traffic(340);

    // Roles swap: sender idles often, receiver rarely.
    settle();
    src_gap_pct    = 59;
    sink_stall_pct = 6;
    load_random_timing();
    traffic(340);

    // No idling; hold the result side once so the core backs up.
    settle();
    src_gap_pct    = 0;
    sink_stall_pct = 0;
    load_random_timing();
    hold_req = 1'b1;
    traffic(340);

    settle();
    load_random_timing();
    traffic(340);
    settle();

    if (mismatches == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

@@ nec_ir_frame_transmitter_core.f @@
rtl/core/nec_tx_pkg.sv
rtl/core/nec_ir_frame_transmitter_core.sv
rtl/core/nec_tx_checker.sv
tb/sv/testbench.sv
